// ===== hw/rtl/double_ended_queue_core_assert.svh =====
// ----------------------------------------------------------------------------
// double_ended_queue_core_assert.svh
// Assertion macros for the deque core. Clock clk, reset arst_n.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_CORE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_CORE_ASSERT_SVH

// same-cycle implication
`define DQC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define DQC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/dqc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqc_pkg
// Types and constants shared by the deque core and its interfaces.
// ----------------------------------------------------------------------------
package dqc_pkg;

	localparam int DEPTH  = 16;
	localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int DATA_W = 32;
	localparam int OCC_W  = 5;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [OCC_W-1:0] occ_t;

	typedef enum logic [1:0] {
		OP_PUSH_REAR  = 2'd0,
		OP_PUSH_FRONT = 2'd1,
		OP_POP_REAR   = 2'd2,
		OP_POP_FRONT  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	localparam idx_t IDX_LAST = idx_t'(DEPTH - 1);
	localparam cnt_t CNT_FULL = cnt_t'(DEPTH);

	function automatic idx_t ring_next(idx_t i);
		return (i == IDX_LAST) ? '0 : idx_t'(i + 1'b1);
	endfunction

	function automatic idx_t ring_prev(idx_t i);
		return (i == '0) ? IDX_LAST : idx_t'(i - 1'b1);
	endfunction

endpackage

// ===== hw/rtl/dqc_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqc_if
// Request and response channels of the deque core: valid/ready plus payload.
// ----------------------------------------------------------------------------
interface dqc_req_if;
	logic               valid;
	logic               ready;
	dqc_pkg::op_t       opcode;
	logic signed [31:0] value;

	modport source (output valid, output opcode, output value, input ready);
	modport sink   (input valid, input opcode, input value, output ready);
endinterface

interface dqc_rsp_if;
	logic                valid;
	logic                ready;
	logic signed [31:0]  popped_value;
	dqc_pkg::status_t    status;
	logic [4:0]          occupancy;

	modport source (output valid, output popped_value, output status,
		output occupancy, input ready);
	modport sink   (input valid, input popped_value, input status,
		input occupancy, output ready);
endinterface

// ===== hw/rtl/dqc_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqc_ram
// Single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module dqc_ram #(
	parameter int ADDR_W = 4,
	parameter int DATA_W = 32
) (
	input  logic              clk,
	input  logic              en,
	input  logic              we,
	input  logic [ADDR_W-1:0] addr,
	input  logic [DATA_W-1:0] wdata,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [2**ADDR_W];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata_q <= mem[addr];
			end
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== hw/rtl/double_ended_queue_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue_core
// Deque of signed 32-bit words in a ring buffer RAM with front/rear pointers.
// ----------------------------------------------------------------------------
//  channel | dir | payload                              | transfer when
//  req     | in  | opcode, value                        | req.valid & req.ready
//  rsp     | out | popped_value, status, occupancy      | rsp.valid & rsp.ready
//
//  One request per cycle sustained while rsp does not stall; each result
//  passes through the RAM read stage, then the output register.
//  Pointers and count update at the request transfer, so the RAM port is the
//  only shared resource and each request uses it at most once.
//  Reset clears pointers, count and valids; RAM contents are left as is.
//  A stall on rsp backs up through the read stage into req.ready.
// ----------------------------------------------------------------------------
module double_ended_queue_core (
	input  logic   clk,
	input  logic   arst_n,
	dqc_req_if.sink   req,
	dqc_rsp_if.source rsp
);
	import dqc_pkg::*;

	idx_t front_q, rear_q, front_d, rear_d;
	cnt_t count_q, count_d;

	logic    accept;
	logic    full, empty;
	logic    ram_en, ram_we;
	idx_t    ram_addr;
	logic [DATA_W-1:0] ram_rdata;
	logic    pop_ok;
	status_t status_d;

	logic    valid_s1;
	logic    pop_s1;
	status_t status_s1;
	occ_t    occ_s1;

	logic    out_valid_q;
	logic [DATA_W-1:0] out_value_q;
	status_t out_status_q;
	occ_t    out_occ_q;

	logic out_load;

	assign out_load  = valid_s1 && (!out_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || !out_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;

	assign full  = (count_q == CNT_FULL);
	assign empty = (count_q == '0);

	always_comb begin
		front_d  = front_q;
		rear_d   = rear_q;
		count_d  = count_q;
		ram_en   = 1'b0;
		ram_we   = 1'b0;
		ram_addr = rear_q;
		pop_ok   = 1'b0;
		status_d = ST_DONE;
		case (req.opcode)
			OP_PUSH_REAR: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					ram_en   = 1'b1;
					ram_we   = 1'b1;
					ram_addr = rear_q;
					rear_d   = ring_next(rear_q);
					count_d  = cnt_t'(count_q + 1'b1);
				end
			end
			OP_PUSH_FRONT: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					ram_en   = 1'b1;
					ram_we   = 1'b1;
					ram_addr = ring_prev(front_q);
					front_d  = ring_prev(front_q);
					count_d  = cnt_t'(count_q + 1'b1);
				end
			end
			OP_POP_REAR: begin
				if (empty) begin
					status_d = ST_EMPTY;
				end else begin
					ram_en   = 1'b1;
					pop_ok   = 1'b1;
					ram_addr = ring_prev(rear_q);
					rear_d   = ring_prev(rear_q);
					count_d  = cnt_t'(count_q - 1'b1);
				end
			end
			OP_POP_FRONT: begin
				if (empty) begin
					status_d = ST_EMPTY;
				end else begin
					ram_en   = 1'b1;
					pop_ok   = 1'b1;
					ram_addr = front_q;
					front_d  = ring_next(front_q);
					count_d  = cnt_t'(count_q - 1'b1);
				end
			end
			default: begin
				status_d = ST_DONE;
			end
		endcase
	end

	dqc_ram #(
		.ADDR_W (IDX_W),
		.DATA_W (DATA_W)
	) u_ram (
		.clk   (clk),
		.en    (accept && ram_en),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (req.value),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			rear_q  <= '0;
			count_q <= '0;
		end else if (accept) begin
			front_q <= front_d;
			rear_q  <= rear_d;
			count_q <= count_d;
		end
	end

	// read stage: RAM data lands here in the cycle after the transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pop_s1    <= pop_ok;
			status_s1 <= status_d;
			occ_s1    <= occ_t'(count_d);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_value_q  <= pop_s1 ? ram_rdata : '0;
			out_status_q <= status_s1;
			out_occ_q    <= occ_s1;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.popped_value = out_value_q;
	assign rsp.status       = out_status_q;
	assign rsp.occupancy    = out_occ_q;

	`include "double_ended_queue_core_assert.svh"

	`DQC_ASSERT_NOW(a_count_range, 1'b1, count_q <= CNT_FULL, "count above depth")
	`DQC_ASSERT_NOW(a_ptr_meet, (count_q == '0) || (count_q == CNT_FULL), front_q == rear_q, "pointers disagree with count")
	`DQC_ASSERT_NXT(a_accept_s1, accept, valid_s1, "accepted request lost before read stage")
	`DQC_ASSERT_NOW(a_full_occ, rsp.valid && (rsp.status == ST_FULL), rsp.occupancy == occ_t'(DEPTH), "full status with wrong occupancy")

endmodule
